[design/fdtq_pkg.sv]
// fdtq_pkg: shared types and constants of the timeout queue block
// depends on nothing
`default_nettype none
package fdtq_pkg;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned QIDX_W  = 2;
	localparam int unsigned EID_W   = 5;
	localparam int unsigned TIME_W  = 64;
	localparam int unsigned DUR_W   = 32;
	localparam int unsigned CNT_W   = 6;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned MAXQ    = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 32;

	localparam logic [MODE_W-1:0] MODE_LINK   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_UNLINK = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RUNQ   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RUNALL = 3'd3;
	localparam logic [MODE_W-1:0] MODE_WAKE   = 3'd4;

	localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WAKE    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd3;

	localparam logic [TIME_W-1:0] TIME_ALL_ONES = '1;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [QIDX_W-1:0] queue_index;
		logic [EID_W-1:0]  entry_id;
		logic [TIME_W-1:0] now;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [EID_W-1:0]  expired_entry;
		logic [CNT_W-1:0]  expired_count;
		logic [TIME_W-1:0] wake_time;
		logic              status;
		logic              last;
	} res_t;

	// command handed from front to back, already classified
	typedef enum logic [2:0] {
		OP_REJECT, OP_LINK, OP_UNLINK, OP_RUN, OP_WAKE
	} op_t;

	typedef struct packed {
		op_t               op;
		logic              run_all;
		logic [QIDX_W-1:0] q;
		logic [EID_W-1:0]  e;
		logic [TIME_W-1:0] now;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RUN_CHECK, ST_RUN_POP, ST_RUN_NEXTQ, ST_UNLINK, ST_WAKE,
		ST_EMIT
	} state_t;
endpackage
`default_nettype wire

[design/fdtq_if.sv]
// fdtq_if: valid/ready channel carrying one word of a given type
// depends on nothing
`default_nettype none
interface fdtq_if #(parameter int unsigned W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/fixed_duration_timeout_queues.sv]
// fixed_duration_timeout_queues: top level, configuration registers and channels
// depends on fdtq_pkg, fdtq_if, fdtq_front, fdtq_back
`default_nettype none
// Timeout queues sharing a pool of entry slots, each queue with its own
// duration. A front stage takes commands into a two-word job queue; a back
// sequencer runs them against linked lists held in registers. A run checks
// the head of each queue it looks at and pops it while it has expired; a
// wake query scans every queue. Results leave through an output register so
// the next job may start while one waits.
module fixed_duration_timeout_queues #(
	parameter int unsigned ENTRIES = 32,
	parameter int unsigned QUEUES  = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	fdtq_if.sink     in_ch,
	fdtq_if.source   out_ch,
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic [fdtq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [fdtq_pkg::CFG_DAT_W-1:0] cfg_data
);
	logic [QUEUES-1:0][fdtq_pkg::DUR_W-1:0] dur_q;
	logic           job_valid, job_ready;
	fdtq_pkg::job_t job;
	fdtq_pkg::res_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q <= '0;
		end else if (cfg_valid) begin
			for (int i = 0; i < QUEUES; i++)
				if (32'(cfg_index) == i) dur_q[i] <= cfg_data;
		end
	end

	fdtq_front #(.ENTRIES(ENTRIES), .QUEUES(QUEUES)) u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.data),
		.job_valid, .job_ready, .job
	);

	fdtq_back #(.ENTRIES(ENTRIES), .QUEUES(QUEUES)) u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job, .dur(dur_q),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(res)
	);
	assign out_ch.data = res;

	// a non-final word is always an expired entry
	a_nonlast_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !res.last |-> res.kind == fdtq_pkg::KIND_EXPIRED)
		else $error("non-final word not an expiry");
	// an expired word is never final
	a_expired_notlast: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && res.kind == fdtq_pkg::KIND_EXPIRED |-> !res.last)
		else $error("expiry flagged last");
	// count never exceeds the pool
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && res.kind == fdtq_pkg::KIND_DONE |-> 32'(res.expired_count) <= ENTRIES)
		else $error("run count too large");
endmodule
`default_nettype wire

[design/fdtq_front.sv]
// fdtq_front: accepts commands, classifies them into jobs, two-deep job queue
// depends on fdtq_pkg
`default_nettype none
module fdtq_front #(
	parameter int unsigned ENTRIES = 32,
	parameter int unsigned QUEUES  = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire fdtq_pkg::cmd_t        in_cmd,
	output logic                       job_valid,
	input  wire logic                  job_ready,
	output fdtq_pkg::job_t             job
);
	fdtq_pkg::job_t job_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     fill_q;
	fdtq_pkg::job_t cls;
	logic           push, pop;

	always_comb begin
		cls         = '0;
		cls.q       = in_cmd.queue_index;
		cls.e       = in_cmd.entry_id;
		cls.now     = in_cmd.now;
		cls.op      = fdtq_pkg::OP_REJECT;
		cls.run_all = 1'b0;
		case (in_cmd.mode)
			fdtq_pkg::MODE_LINK: begin
				if (32'(in_cmd.entry_id) < ENTRIES && 32'(in_cmd.queue_index) < QUEUES)
					cls.op = fdtq_pkg::OP_LINK;
			end
			fdtq_pkg::MODE_UNLINK: begin
				if (32'(in_cmd.entry_id) < ENTRIES) cls.op = fdtq_pkg::OP_UNLINK;
			end
			fdtq_pkg::MODE_RUNQ:   cls.op = fdtq_pkg::OP_RUN;
			fdtq_pkg::MODE_RUNALL: begin
				cls.op      = fdtq_pkg::OP_RUN;
				cls.run_all = 1'b1;
				cls.q       = '0;
			end
			fdtq_pkg::MODE_WAKE:   cls.op = fdtq_pkg::OP_WAKE;
			default:               cls.op = fdtq_pkg::OP_REJECT;
		endcase
	end

	assign in_ready  = (fill_q != 2'd2);
	assign job_valid = (fill_q != 2'd0);
	assign job       = job_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = job_valid && job_ready;

	always_ff @(posedge clk) begin
		if (push) job_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

[design/fdtq_back.sv]
// fdtq_back: slot lists, run, unlink and wake sequencer with output register
// depends on fdtq_pkg
`default_nettype none
module fdtq_back #(
	parameter int unsigned ENTRIES = 32,
	parameter int unsigned QUEUES  = 4
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                job_valid,
	output logic                                     job_ready,
	input  wire fdtq_pkg::job_t                      job,
	input  wire logic [QUEUES-1:0][fdtq_pkg::DUR_W-1:0] dur,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output fdtq_pkg::res_t                           out_res
);
	localparam int unsigned SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

	logic [fdtq_pkg::TIME_W-1:0] stamp_q [ENTRIES];
	logic [QW-1:0] squeue_q [ENTRIES];
	logic [SW-1:0] next_q [ENTRIES];
	logic [SW-1:0] prev_q [ENTRIES];
	logic [ENTRIES-1:0] linked_q;
	logic [SW-1:0] head_q [QUEUES];
	logic [SW-1:0] tail_q [QUEUES];
	logic [QUEUES-1:0] nonempty_q;

	fdtq_pkg::state_t state_q, state_d;
	fdtq_pkg::job_t   cur_q;
	logic [fdtq_pkg::CNT_W-1:0] count_q;
	logic [QW:0]      wq_q;          // wake scan queue counter
	logic [fdtq_pkg::TIME_W-1:0] wake_q;
	logic [fdtq_pkg::TIME_W-1:0] limit_q;
	logic             out_valid_q;
	fdtq_pkg::res_t   out_q;
	fdtq_pkg::res_t   pend_q;        // word being built, copied to out_q when free

	logic [SW-1:0] e_ix, rm_ix;
	logic [QW-1:0] cq;
	logic          cq_ok;
	logic          out_free;
	logic          out_load;
	logic          do_remove;
	logic          wake_take;
	logic [SW-1:0] h;
	logic [fdtq_pkg::TIME_W-1:0] wcand;

	assign e_ix     = cur_q.e[SW-1:0];
	assign cq       = cur_q.q[QW-1:0];
	assign cq_ok    = 32'(cur_q.q) < QUEUES;
	assign out_free = !out_valid_q || out_ready;
	assign h        = head_q[cq];
	assign wcand    = stamp_q[head_q[wq_q[QW-1:0]]] + 64'(dur[wq_q[QW-1:0]]);
	assign wake_take = nonempty_q[wq_q[QW-1:0]] && wcand < wake_q;
	assign job_ready = (state_q == fdtq_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign out_load  = out_free && (state_q == fdtq_pkg::ST_RUN_POP ||
		state_q == fdtq_pkg::ST_UNLINK || state_q == fdtq_pkg::ST_EMIT);

	// remove one slot: popped head in a run or unlink target
	assign do_remove = (state_q == fdtq_pkg::ST_RUN_POP && out_free) ||
		(state_q == fdtq_pkg::ST_UNLINK && out_free && linked_q[e_ix]);
	assign rm_ix = (state_q == fdtq_pkg::ST_RUN_POP) ? h : e_ix;

	always_comb begin
		state_d = state_q;
		case (state_q)
			fdtq_pkg::ST_IDLE: begin
				if (job_valid) begin
					case (job.op)
						fdtq_pkg::OP_RUN:    state_d = fdtq_pkg::ST_RUN_CHECK;
						fdtq_pkg::OP_UNLINK: state_d = fdtq_pkg::ST_UNLINK;
						fdtq_pkg::OP_WAKE:   state_d = fdtq_pkg::ST_WAKE;
						default:             state_d = fdtq_pkg::ST_EMIT;
					endcase
				end
			end
			fdtq_pkg::ST_RUN_CHECK: begin
				if (cq_ok && nonempty_q[cq] && stamp_q[h] <= limit_q)
					state_d = fdtq_pkg::ST_RUN_POP;
				else
					state_d = fdtq_pkg::ST_RUN_NEXTQ;
			end
			fdtq_pkg::ST_RUN_POP: if (out_free) state_d = fdtq_pkg::ST_RUN_CHECK;
			fdtq_pkg::ST_RUN_NEXTQ: begin
				if (cur_q.run_all && 32'(cur_q.q) + 1 < QUEUES)
					state_d = fdtq_pkg::ST_RUN_CHECK;
				else
					state_d = fdtq_pkg::ST_EMIT;
			end
			fdtq_pkg::ST_UNLINK: if (out_free) state_d = fdtq_pkg::ST_IDLE;
			fdtq_pkg::ST_WAKE: begin
				if (32'(wq_q) + 1 >= QUEUES) state_d = fdtq_pkg::ST_EMIT;
			end
			fdtq_pkg::ST_EMIT: if (out_free) state_d = fdtq_pkg::ST_IDLE;
			default: state_d = fdtq_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fdtq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			linked_q    <= '0;
			nonempty_q  <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			case (state_q)
				fdtq_pkg::ST_IDLE: begin
					if (job_valid && job.op == fdtq_pkg::OP_LINK &&
							!linked_q[job.e[SW-1:0]]) begin
						linked_q[job.e[SW-1:0]] <= 1'b1;
						nonempty_q[job.q[QW-1:0]] <= 1'b1;
					end
				end
				default: ;
			endcase
			if (do_remove) begin
				linked_q[rm_ix] <= 1'b0;
				if (head_q[squeue_q[rm_ix]] == rm_ix && tail_q[squeue_q[rm_ix]] == rm_ix)
					nonempty_q[squeue_q[rm_ix]] <= 1'b0;
			end
		end
	end

	// payload, lists and sequencing data
	always_ff @(posedge clk) begin
		case (state_q)
			fdtq_pkg::ST_IDLE: begin
				if (job_valid) begin
					cur_q   <= job;
					count_q <= '0;
					wq_q    <= '0;
					wake_q  <= fdtq_pkg::TIME_ALL_ONES;
					limit_q <= job.now - 64'(dur[job.q[QW-1:0]]);
					pend_q  <= '{kind: fdtq_pkg::KIND_STATUS,
						status: !(job.op == fdtq_pkg::OP_LINK && !linked_q[job.e[SW-1:0]]),
						last: 1'b1, default: '0};
					if (job.op == fdtq_pkg::OP_LINK && !linked_q[job.e[SW-1:0]]) begin
						if (nonempty_q[job.q[QW-1:0]]) begin
							next_q[tail_q[job.q[QW-1:0]]] <= job.e[SW-1:0];
							prev_q[job.e[SW-1:0]] <= tail_q[job.q[QW-1:0]];
						end else begin
							head_q[job.q[QW-1:0]] <= job.e[SW-1:0];
							prev_q[job.e[SW-1:0]] <= job.e[SW-1:0];
						end
						next_q[job.e[SW-1:0]]   <= job.e[SW-1:0];
						tail_q[job.q[QW-1:0]]   <= job.e[SW-1:0];
						squeue_q[job.e[SW-1:0]] <= job.q[QW-1:0];
						stamp_q[job.e[SW-1:0]]  <= job.now;
					end
				end
			end
			fdtq_pkg::ST_RUN_POP: begin
				if (out_free) begin
					out_q <= '{kind: fdtq_pkg::KIND_EXPIRED,
						expired_entry: fdtq_pkg::EID_W'(h), default: '0};
					count_q <= count_q + 1'b1;
				end
			end
			fdtq_pkg::ST_RUN_NEXTQ: begin
				cur_q.q <= cur_q.q + 1'b1;
				limit_q <= cur_q.now - 64'(dur[QW'(cq + 1'b1)]);
				pend_q  <= '{kind: fdtq_pkg::KIND_DONE, expired_count: count_q,
					last: 1'b1, default: '0};
			end
			fdtq_pkg::ST_UNLINK: begin
				if (out_free)
					out_q <= '{kind: fdtq_pkg::KIND_STATUS, status: !linked_q[e_ix],
						last: 1'b1, default: '0};
			end
			fdtq_pkg::ST_WAKE: begin
				wake_q <= wake_take ? wcand : wake_q;
				pend_q <= '{kind: fdtq_pkg::KIND_WAKE,
					wake_time: (wake_take ? wcand : wake_q), last: 1'b1, default: '0};
				wq_q <= wq_q + 1'b1;
			end
			fdtq_pkg::ST_EMIT: begin
				if (out_free) out_q <= pend_q;
			end
			default: ;
		endcase
		if (do_remove) begin
			if (!(head_q[squeue_q[rm_ix]] == rm_ix && tail_q[squeue_q[rm_ix]] == rm_ix)) begin
				if (head_q[squeue_q[rm_ix]] == rm_ix)
					head_q[squeue_q[rm_ix]] <= next_q[rm_ix];
				else
					next_q[prev_q[rm_ix]] <= next_q[rm_ix];
				if (tail_q[squeue_q[rm_ix]] == rm_ix)
					tail_q[squeue_q[rm_ix]] <= prev_q[rm_ix];
				else
					prev_q[next_q[rm_ix]] <= prev_q[rm_ix];
			end
		end
	end
endmodule
`default_nettype wire
